// File: hdl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// shared types, constants and plane geometry helpers of the deinterlacer
// ----------------------------------------------------------------------------
`default_nettype none

package lbd_pkg;

  localparam int unsigned MaxLineDef = 4096;
  localparam int unsigned BlockRows  = 8;
  localparam int unsigned RowCap     = 4096;
  localparam int unsigned PixW       = 8;
  localparam int unsigned PosW       = 12;
  localparam int unsigned DimW       = 13;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned ResDepth   = 4;

  localparam logic [DimW-1:0] FrameWidthRst  = 13'd720;
  localparam logic [DimW-1:0] FrameHeightRst = 13'd480;

  typedef enum logic [0:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            last_of_item;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [DimW-1:0] plane_dim(input logic [DimW-1:0] v, input logic half,
                                                input logic [DimW-1:0] cap);
    logic [DimW-1:0] d;
    d = half ? (v >> 1) : v;
    if (d == '0) d = DimW'(1);
    if (d > cap) d = cap;
    return d;
  endfunction

  function automatic logic [PosW-1:0] filter_limit(input logic [DimW-1:0] h);
    logic [DimW-1:0] up;
    logic [DimW-1:0] hm2;
    up  = '0;
    hm2 = h - DimW'(2);
    if (h > DimW'(BlockRows)) begin
      up = ((h - DimW'(8)) + DimW'(BlockRows - 1)) / DimW'(BlockRows) * DimW'(BlockRows);
      if (up > hm2) up = hm2;
    end
    return up[PosW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/lbd_if.sv
// ----------------------------------------------------------------------------
// lbd_if
// sample and result channels of the deinterlacer
// ----------------------------------------------------------------------------
`default_nettype none

interface lbd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lbd_pkg::PixW-1:0]  pixel_in;
  logic                      plane_start;
  logic                      chroma_plane;

  modport source (output valid, pixel_in, plane_start, chroma_plane, input ready);
  modport sink   (input valid, pixel_in, plane_start, chroma_plane, output ready);
endinterface

interface lbd_out_if;
  logic                      valid;
  logic                      ready;
  logic [lbd_pkg::PixW-1:0]  pixel_out;
  logic [lbd_pkg::PosW-1:0]  out_row;
  logic [lbd_pkg::PosW-1:0]  out_col;
  logic                      last_of_item;

  modport source (output valid, pixel_out, out_row, out_col, last_of_item, input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, last_of_item, output ready);
endinterface

`default_nettype wire

// File: hdl/lbd_ram.sv
// ----------------------------------------------------------------------------
// lbd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/lbd_res_fifo.sv
// ----------------------------------------------------------------------------
// lbd_res_fifo
// small result queue, takes up to two results a cycle and gives one
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_res_fifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lbd_pkg::push_t                 push_i,
  input  wire logic                           pop_i,
  output lbd_pkg::res_t                       head_o,
  output logic                                valid_o,
  output logic [$clog2(lbd_pkg::ResDepth):0]  count_o
);

  localparam int unsigned PtrW = $clog2(lbd_pkg::ResDepth);

  lbd_pkg::res_t   mem_q [lbd_pkg::ResDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic [PtrW-1:0] wptr_nx;

  assign wptr_nx = wptr_q + PtrW'(1);
  assign wptr_d  = wptr_q + PtrW'(push_i.cnt);
  assign rptr_d  = rptr_q + PtrW'(pop_i);
  assign cnt_d   = cnt_q + (PtrW+1)'(push_i.cnt) - (PtrW+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_nx] <= push_i.second;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// File: hdl/linear_blend_deinterlacer_top.sv
// ----------------------------------------------------------------------------
// linear_blend_deinterlacer_top
// vertical 1-2-1 blend deinterlacer for one image plane
//
// pix_i takes one sample per transfer in raster order; plane_start marks the
// first sample of a plane and latches chroma_plane (half width and height).
// res_o gives the results: a row below the filter limit is blended from three
// original rows and leaves when the sample two rows below arrives, rows at or
// above the limit pass through; last_of_item marks the final result of a
// sample. frame_width and frame_height are written over the apb port.
// The two previous rows sit in one ram, read when a sample is taken and
// written back in the next cycle with forwarding for back-to-back hits.
// A result is formed in the blend stage after its sample transfer and leaves
// from the result queue. One sample per cycle is taken while pix_i.ready is
// high; the two rows at and just above the limit give two results per sample,
// and there the single result port limits the sample rate.
// After reset a clearing pass zeroes every entry of the line ram, and
// pix_i.ready stays low meanwhile. A stalled receiver backs results up into
// a four-entry queue; pix_i.ready drops once it could not take two more.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_deinterlacer_top #(
  parameter int unsigned MaxLine = lbd_pkg::MaxLineDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lbd_pkg::AddrW-1:0]   paddr,
  input  wire logic [lbd_pkg::DataW-1:0]   pwdata,
  output logic      [lbd_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  lbd_in_if.sink                           pix_i,
  lbd_out_if.source                        res_o
);

  localparam int unsigned AW   = $clog2(MaxLine);
  localparam int unsigned WCap = (MaxLine < lbd_pkg::RowCap) ? MaxLine : lbd_pkg::RowCap;
  localparam int unsigned DW   = lbd_pkg::DimW;
  localparam int unsigned PW   = lbd_pkg::PosW;
  localparam int unsigned XW   = lbd_pkg::PixW;
  localparam int unsigned CW   = $clog2(lbd_pkg::ResDepth) + 1;

  // configuration and derived plane geometry
  logic [DW-1:0] fw_q, fh_q;
  logic [DW-1:0] wfull_q, whalf_q;
  logic [PW-1:0] ffull_q, fhalf_q;
  logic          cfg_wr;
  lbd_pkg::reg_idx_e cfg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = lbd_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= lbd_pkg::FrameWidthRst;
      fh_q    <= lbd_pkg::FrameHeightRst;
      wfull_q <= lbd_pkg::plane_dim(lbd_pkg::FrameWidthRst, 1'b0, DW'(WCap));
      whalf_q <= lbd_pkg::plane_dim(lbd_pkg::FrameWidthRst, 1'b1, DW'(WCap));
      ffull_q <= lbd_pkg::filter_limit(
                   lbd_pkg::plane_dim(lbd_pkg::FrameHeightRst, 1'b0, DW'(lbd_pkg::RowCap)));
      fhalf_q <= lbd_pkg::filter_limit(
                   lbd_pkg::plane_dim(lbd_pkg::FrameHeightRst, 1'b1, DW'(lbd_pkg::RowCap)));
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        lbd_pkg::RegFrameWidth: begin
          fw_q    <= pwdata[DW-1:0];
          wfull_q <= lbd_pkg::plane_dim(pwdata[DW-1:0], 1'b0, DW'(WCap));
          whalf_q <= lbd_pkg::plane_dim(pwdata[DW-1:0], 1'b1, DW'(WCap));
        end
        lbd_pkg::RegFrameHeight: begin
          fh_q    <= pwdata[DW-1:0];
          ffull_q <= lbd_pkg::filter_limit(
                       lbd_pkg::plane_dim(pwdata[DW-1:0], 1'b0, DW'(lbd_pkg::RowCap)));
          fhalf_q <= lbd_pkg::filter_limit(
                       lbd_pkg::plane_dim(pwdata[DW-1:0], 1'b1, DW'(lbd_pkg::RowCap)));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      lbd_pkg::RegFrameWidth:  prdata = {{(lbd_pkg::DataW-DW){1'b0}}, fw_q};
      lbd_pkg::RegFrameHeight: prdata = {{(lbd_pkg::DataW-DW){1'b0}}, fh_q};
      default:                 prdata = '0;
    endcase
  end

  // line ram clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MaxLine - 1)) clr_busy_q <= 1'b0;
    end
  end

  // sample transfer: position update and ram read
  logic          half_q, half_d;
  logic [PW-1:0] row_q, row_d, col_q, col_d;
  logic [PW-1:0] row_s, col_s, r_a, c_a;
  logic [DW-1:0] w_a, cn_a, c_ext;
  logic [PW-1:0] f_a;
  logic          take;

  assign take = pix_i.valid && pix_i.ready;

  always_comb begin
    half_d = pix_i.plane_start ? pix_i.chroma_plane : half_q;
    w_a    = half_d ? whalf_q : wfull_q;
    f_a    = half_d ? fhalf_q : ffull_q;
    row_s  = pix_i.plane_start ? '0 : row_q;
    col_s  = pix_i.plane_start ? '0 : col_q;
    if ({1'b0, col_s} >= w_a) begin
      c_a = '0;
      r_a = row_s + PW'(1);
    end else begin
      c_a = col_s;
      r_a = row_s;
    end
    cn_a = {1'b0, c_a} + DW'(1);
    if (cn_a >= w_a) begin
      col_d = '0;
      row_d = r_a + PW'(1);
    end else begin
      col_d = cn_a[PW-1:0];
      row_d = r_a;
    end
    c_ext = {1'b0, c_a};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (take) begin
      half_q <= half_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  // blend stage: ram data back, write back, results out
  logic            v1_q;
  logic [XW-1:0]   pix1_q;
  logic [PW-1:0]   r1_q, c1_q, f1_q;
  logic            fwd1_q;
  logic [2*XW-1:0] fwdd_q;
  logic [2*XW-1:0] rdata, rd1;
  logic [XW-1:0]   older1, newer1;
  logic [XW+1:0]   sum1;
  logic            filt1, pass1;
  logic [1:0]      n1;
  logic [DW-1:0]   c1_ext;

  assign rd1    = fwd1_q ? fwdd_q : rdata;
  assign older1 = rd1[2*XW-1:XW];
  assign newer1 = rd1[XW-1:0];
  assign c1_ext = {1'b0, c1_q};
  assign sum1   = {2'b00, older1} + {1'b0, newer1, 1'b0} + {2'b00, pix1_q};
  assign filt1  = v1_q && (r1_q >= PW'(2)) && ((r1_q - PW'(2)) < f1_q);
  assign pass1  = v1_q && (r1_q >= f1_q);
  assign n1     = {1'b0, filt1} + {1'b0, pass1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pix1_q <= pix_i.pixel_in;
      r1_q   <= r_a;
      c1_q   <= c_a;
      f1_q   <= f_a;
      fwd1_q <= v1_q && (c_a == c1_q);
      fwdd_q <= {newer1, pix1_q};
    end
  end

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [2*XW-1:0] ram_wdata;

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = v1_q;
      ram_waddr = c1_ext[AW-1:0];
      ram_wdata = {newer1, pix1_q};
    end
  end

  lbd_ram #(
    .Width (2 * XW),
    .Depth (MaxLine)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (c_ext[AW-1:0]),
    .rdata_o (rdata)
  );

  lbd_pkg::res_t  res_filt, res_pass, head;
  lbd_pkg::push_t push;
  logic [CW-1:0]  fifo_cnt;
  logic           fifo_valid;

  always_comb begin
    res_filt.pixel_out    = sum1[XW+1:2];
    res_filt.out_row      = r1_q - PW'(2);
    res_filt.out_col      = c1_q;
    res_filt.last_of_item = !pass1;
    res_pass.pixel_out    = pix1_q;
    res_pass.out_row      = r1_q;
    res_pass.out_col      = c1_q;
    res_pass.last_of_item = 1'b1;
    push.cnt    = n1;
    push.first  = filt1 ? res_filt : res_pass;
    push.second = res_pass;
  end

  lbd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (res_o.valid && res_o.ready),
    .head_o  (head),
    .valid_o (fifo_valid),
    .count_o (fifo_cnt)
  );

  assign pix_i.ready = !clr_busy_q &&
                       (({1'b0, fifo_cnt} + (CW+1)'(n1) + (CW+1)'(2)) <=
                        (CW+1)'(lbd_pkg::ResDepth));

  assign res_o.valid        = fifo_valid;
  assign res_o.pixel_out    = head.pixel_out;
  assign res_o.out_row      = head.out_row;
  assign res_o.out_col      = head.out_col;
  assign res_o.last_of_item = head.last_of_item;

endmodule

`default_nettype wire

// File: hdl/lbd_checker.sv
// ----------------------------------------------------------------------------
// lbd_checker
// port-level checks of the deinterlacer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      psel,
  input wire logic                      penable,
  input wire logic                      pwrite,
  input wire logic [lbd_pkg::AddrW-1:0] paddr,
  input wire logic [lbd_pkg::DataW-1:0] pwdata,
  input wire logic [lbd_pkg::DataW-1:0] prdata,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [lbd_pkg::PixW-1:0]  out_pixel,
  input wire logic [lbd_pkg::PosW-1:0]  out_row,
  input wire logic [lbd_pkg::PosW-1:0]  out_col,
  input wire logic                      out_last
);

  // a blended result is always followed at once by the pass-through below it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=>
      out_valid && out_col == $past(out_col) &&
      out_row == $past(out_row) + lbd_pkg::PosW'(2))
    else $error("blended result not followed by its pass-through");

  // register read back after write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=>
      paddr[2] != $past(paddr[2]) ||
      prdata[lbd_pkg::DimW-1:0] == $past(pwdata[lbd_pkg::DimW-1:0]))
    else $error("register read back mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable(out_pixel) && $stable(out_row) && $stable(out_col) && $stable(out_last))
    else $error("result payload changed while stalled");

endmodule

bind linear_blend_deinterlacer_top lbd_checker u_lbd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_pixel (res_o.pixel_out),
  .out_row   (res_o.out_row),
  .out_col   (res_o.out_col),
  .out_last  (res_o.last_of_item)
);

`default_nettype wire

// File: test/tb_linear_blend_deinterlacer_top.sv
// ----------------------------------------------------------------------------
// tb_linear_blend_deinterlacer_top
// self-checking bench for the vertical 1-2-1 blend deinterlacer
//
// Samples go in over pix_i and results come out of res_o. A scoreboard holds
// its own copy of the line stores, row and column counters and plane geometry.
// For every sample transfer it queues the blended and passed-through results
// it expects, and it checks each result transfer against the oldest entry.
// A short directed stretch covers extreme sample values, the height that is
// one above a multiple of eight, and a width shrunk part way through a row.
// Randomised phases follow with several plane sizes, each register set to
// the 4096 cap in one phase, and different idle and stall profiles.
// ----------------------------------------------------------------------------

class deint_scoreboard;
  logic [lbd_pkg::DimW-1:0] width_reg  = lbd_pkg::FrameWidthRst;
  logic [lbd_pkg::DimW-1:0] height_reg = lbd_pkg::FrameHeightRst;
  bit                       half_mode;
  int unsigned              row_pos;
  int unsigned              col_pos;
  bit [7:0]                 row_older [4096];
  bit [7:0]                 row_newer [4096];
  lbd_pkg::res_t            pending [$];
  int unsigned              errors;

  function void set_reg(lbd_pkg::reg_idx_e idx, logic [lbd_pkg::DimW-1:0] val);
    if (idx == lbd_pkg::RegFrameWidth) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
  endfunction

  function int unsigned span(logic [lbd_pkg::DimW-1:0] v, bit half);
    int unsigned d;
    d = half ? int'(v) / 2 : int'(v);
    if (d == 0) d = 1;
    if (d > 4096) d = 4096;
    return d;
  endfunction

  function void take_sample(logic [7:0] pix, logic start, logic chroma);
    int unsigned w, h, lim, r, c, blend, first;
    if (start) begin
      row_pos   = 0;
      col_pos   = 0;
      half_mode = chroma;
    end
    w   = span(width_reg, half_mode);
    h   = span(height_reg, half_mode);
    lim = 0;
    if (h > 8) begin
      lim = (h - 1) / 8 * 8;
      if (lim > h - 2) lim = h - 2;
    end
    // width shrunk mid-row: move on to the next row first
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % 4096;
    end
    r     = row_pos;
    c     = col_pos;
    first = pending.size();
    if (r >= 2 && r - 2 < lim) begin
      blend = (int'(row_older[c]) + 2 * int'(row_newer[c]) + int'(pix)) >> 2;
      pending.push_back(lbd_pkg::res_t'{pixel_out: 8'(blend), out_row: 12'(r - 2),
                                        out_col: 12'(c), last_of_item: 1'b0});
    end
    if (r >= lim) begin
      pending.push_back(lbd_pkg::res_t'{pixel_out: pix, out_row: 12'(r),
                                        out_col: 12'(c), last_of_item: 1'b0});
    end
    if (pending.size() > first) pending[pending.size() - 1].last_of_item = 1'b1;
    row_older[c] = row_newer[c];
    row_newer[c] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % 4096;
    end
  endfunction

  function void report(string what, lbd_pkg::res_t want, lbd_pkg::res_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected pix %0d row %0d col %0d last %0d, got pix %0d row %0d col %0d last %0d",
               what, want.pixel_out, want.out_row, want.out_col, want.last_of_item,
               got.pixel_out, got.out_row, got.out_col, got.last_of_item);
    end
  endfunction

  function void match_result(lbd_pkg::res_t got);
    lbd_pkg::res_t want;
    if (pending.size() == 0) begin
      report("unexpected result", '0, got);
    end else begin
      want = pending.pop_front();
      if (got !== want) report("result mismatch", want, got);
    end
  endfunction

  function void close_out();
    if (pending.size() != 0) begin
      errors += pending.size();
      $display("%0d expected results never arrived", pending.size());
    end
  endfunction
endclass

module tb_linear_blend_deinterlacer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lbd_pkg::AddrW-1:0]   paddr;
  logic [lbd_pkg::DataW-1:0]   pwdata;
  logic [lbd_pkg::DataW-1:0]   prdata;
  logic                        pready;

  lbd_in_if  pix_if ();
  lbd_out_if res_if ();

  linear_blend_deinterlacer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_if),
    .res_o   (res_if)
  );

  deint_scoreboard book;
  int unsigned     src_idle_pct;
  int unsigned     sink_stall_pct;
  int unsigned     cycles;
  int unsigned     src_pct [4] = '{0, 77, 0, 23};
  int unsigned     snk_pct [4] = '{0, 0, 77, 23};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      book.match_result(lbd_pkg::res_t'{pixel_out: res_if.pixel_out,
                                        out_row: res_if.out_row,
                                        out_col: res_if.out_col,
                                        last_of_item: res_if.last_of_item});
    end
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic write_reg(input lbd_pkg::reg_idx_e idx,
                           input logic [lbd_pkg::DimW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lbd_pkg::AddrW'({idx, 2'b00});
    pwdata  <= lbd_pkg::DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    book.set_reg(idx, val);
  endtask

  task automatic send_sample(input logic [7:0] pix, input logic start, input logic chroma);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid        <= 1'b1;
    pix_if.pixel_in     <= pix;
    pix_if.plane_start  <= start;
    pix_if.chroma_plane <= chroma;
    do @(posedge clk_i); while (!pix_if.ready);
    book.take_sample(pix, start, chroma);
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned               budget, w, h, n;
    bit                        start, chroma, first;
    logic [lbd_pkg::DimW-1:0]  wreg, hreg;
    book                = new();
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pix_if.valid        = 1'b0;
    pix_if.pixel_in     = '0;
    pix_if.plane_start  = 1'b0;
    pix_if.chroma_plane = 1'b0;
    res_if.ready        = 1'b0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // chroma plane of height nine: filter limit clamped to seven
    write_reg(lbd_pkg::RegFrameWidth, 13'd32);
    write_reg(lbd_pkg::RegFrameHeight, 13'd18);
    for (int c = 0; c < 16; c++) send_sample((c % 2) ? 8'd0 : 8'd255, c == 0, 1'b1);
    for (int c = 0; c < 10; c++) send_sample((c % 4 < 2) ? 8'd255 : 8'd0, 1'b0, 1'b0);
    settle();
    // shrink the width while the column is past the new end
    write_reg(lbd_pkg::RegFrameWidth, 13'd16);
    for (int c = 0; c < 4; c++) send_sample((c % 2) ? 8'd0 : 8'd255, 1'b0, c[0]);
    settle();

    for (int p = 0; p < 8; p++) begin
      src_idle_pct   = src_pct[p % 4];
      sink_stall_pct = snk_pct[p % 4];
      case (p)
        3: begin
          wreg = 13'd16;
          hreg = 13'd4096;
        end
        5: begin
          wreg = 13'd4096;
          hreg = 13'd16;
        end
        default: begin
          wreg = ($urandom_range(3) == 0) ? lbd_pkg::DimW'($urandom_range(16, 40)) : 13'd16;
          hreg = lbd_pkg::DimW'($urandom_range(16, 34));
        end
      endcase
      write_reg(lbd_pkg::RegFrameWidth, wreg);
      write_reg(lbd_pkg::RegFrameHeight, hreg);
      budget = 145;
      first  = 1'b1;
      while (budget > 0) begin
        start  = !(first && $urandom_range(2) == 0);
        chroma = ($urandom_range(3) != 0);
        w = book.span(wreg, start ? chroma : book.half_mode);
        h = book.span(hreg, start ? chroma : book.half_mode);
        if ($urandom_range(1) == 1) begin
          n = w * h + $urandom_range(0, 2 * w);
        end else begin
          n = $urandom_range(1, w * (h + 1));
        end
        if (n > budget) n = budget;
        for (int k = 0; k < n; k++) begin
          send_sample(8'($urandom_range(255)), start && k == 0,
                      (k == 0) ? chroma : 1'($urandom_range(1)));
        end
        budget -= n;
        first   = 1'b0;
      end
      settle();
    end

    book.close_out();
    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
